// ===== sv/escape_key_decoder_with_line_edit_assert.svh =====
// assertion macros for the key decoder
`ifndef ESCAPE_KEY_DECODER_WITH_LINE_EDIT_ASSERT_SVH
`define ESCAPE_KEY_DECODER_WITH_LINE_EDIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define EKD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ekd check failed");
// next-cycle implication
`define EKD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ekd check failed");
`else
`define EKD_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define EKD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/ekd_pkg.sv =====
package ekd_pkg;

   // line store geometry
   localparam int LINE_MAX = 64;
   localparam int IDX_W    = $clog2(LINE_MAX);
   localparam int CNT_W    = $clog2(LINE_MAX + 1);
   localparam logic [CNT_W-1:0] LINE_MAX_CNT = CNT_W'(LINE_MAX);
   localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);

   // key codes
   localparam logic [7:0] KEY_BS      = 8'd8;
   localparam logic [7:0] KEY_LF      = 8'd10;
   localparam logic [7:0] KEY_CR      = 8'd13;
   localparam logic [7:0] KEY_ESC     = 8'd27;
   localparam logic [7:0] KEY_BRACKET = 8'd91;
   localparam logic [7:0] KEY_QUIT    = 8'd96;
   localparam logic [7:0] KEY_TILDE   = 8'd126;
   localparam logic [7:0] KEY_DEL     = 8'd127;
   localparam logic [7:0] KEY_UP      = 8'd65;
   localparam logic [7:0] KEY_DOWN    = 8'd66;
   localparam logic [7:0] KEY_RIGHT   = 8'd67;
   localparam logic [7:0] KEY_LEFT    = 8'd68;
   localparam logic [7:0] KEY_ONE     = 8'd49;
   localparam logic [7:0] KEY_TWO     = 8'd50;
   localparam logic [7:0] KEY_FIVE    = 8'd53;

   // command codes
   localparam logic [3:0] ACT_NONE        = 4'd0;
   localparam logic [3:0] ACT_RIGHT       = 4'd1;
   localparam logic [3:0] ACT_LEFT        = 4'd2;
   localparam logic [3:0] ACT_UP          = 4'd3;
   localparam logic [3:0] ACT_DOWN        = 4'd4;
   localparam logic [3:0] ACT_SHIFT_LEFT  = 4'd5;
   localparam logic [3:0] ACT_ENTER       = 4'd6;
   localparam logic [3:0] ACT_SHIFT_RIGHT = 4'd7;
   localparam logic [3:0] ACT_LINE        = 4'd8;
   localparam logic [3:0] ACT_QUIT        = 4'd9;

   // write request into the line store
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } wr_req_type;

   // letters, digits and space
   function automatic logic is_printable(input logic [7:0] c);
      logic res;
      res = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
            (c >= 8'd48 && c <= 8'd57) || (c == 8'd32);
      return res;
   endfunction

endpackage

// ===== sv/escape_key_decoder_with_line_edit.sv =====
// Terminal key decoder with line edit. Each item carries one key byte (when
// req_key_present is set), a clear flag that empties the typed line first, and
// a read position; each item yields exactly one result with the command code,
// the new line length and the character at the read position (0 at or past
// the length). One item is taken every cycle while the result side keeps up;
// a result passes through the read stage, which holds the registered read of
// the 64-entry line store, and then the output register. A result waiting on
// rsp_ready holds one further item in the read stage before req_ready drops.
// The line store needs no clearing after reset.
`include "escape_key_decoder_with_line_edit_assert.svh"

module escape_key_decoder_with_line_edit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_key_present,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_clear_line,
   input  logic [5:0]                    req_read_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_command,
   output logic [6:0]                    rsp_line_length,
   output logic [7:0]                    rsp_read_char
);

   ekd_pkg::wr_req_type       wr;
   logic                      accept;
   logic                      s1_advance;
   logic [3:0]                cmd;
   logic [ekd_pkg::CNT_W-1:0] new_len;
   logic [7:0]                rd_data;
   logic                      hit;
   logic                      fwd;

   logic                      s1_valid_ff, s1_valid_in;
   logic [3:0]                s1_cmd_ff;
   logic [ekd_pkg::CNT_W-1:0] s1_len_ff;
   logic                      s1_hit_ff;
   logic                      s1_fwd_ff;
   logic [7:0]                s1_fwd_data_ff;

   logic                      out_valid_ff, out_valid_in;
   logic [3:0]                out_cmd_ff;
   logic [ekd_pkg::CNT_W-1:0] out_len_ff;
   logic [7:0]                out_char_ff;

   // handshake
   assign s1_advance = !out_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   ekd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .key_present (req_key_present),
      .key_byte    (req_key_byte),
      .clear_line  (req_clear_line),
      .wr          (wr),
      .command     (cmd),
      .line_length (new_len)
   );

   ekd_line_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (accept),
      .rd_addr (req_read_index[ekd_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // read position check and write forwarding
   assign hit = {{(ekd_pkg::CNT_W-6){1'b0}}, req_read_index} < new_len;
   assign fwd = wr.en && (wr.addr == req_read_index[ekd_pkg::IDX_W-1:0]);

   // read stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff      <= cmd;
         s1_len_ff      <= new_len;
         s1_hit_ff      <= hit;
         s1_fwd_ff      <= fwd;
         s1_fwd_data_ff <= wr.data;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         out_cmd_ff  <= s1_cmd_ff;
         out_len_ff  <= s1_len_ff;
         out_char_ff <= !s1_hit_ff ? 8'd0 : (s1_fwd_ff ? s1_fwd_data_ff : rd_data);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_command     = out_cmd_ff;
   assign rsp_line_length = out_len_ff;
   assign rsp_read_char   = out_char_ff;

   // checks
   `EKD_ASSERT_NOW(a_len_bound, clock, reset, rsp_valid, rsp_line_length <= ekd_pkg::LINE_MAX_CNT)
   `EKD_ASSERT_NOW(a_cmd_code, clock, reset, rsp_valid, rsp_command <= ekd_pkg::ACT_QUIT)
   `EKD_ASSERT_NOW(a_char_ascii, clock, reset, rsp_valid, rsp_read_char[7] == 1'b0)
   `EKD_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_advance, s1_valid_ff)

endmodule

// ===== sv/ekd_line_ram.sv =====
module ekd_line_ram (
   input  logic                                clock,
   input  ekd_pkg::wr_req_type                 wr,
   input  logic                                rd_en,
   input  logic [ekd_pkg::IDX_W-1:0]           rd_addr,
   output logic [7:0]                          rd_data
);

   logic [7:0] mem_ff [ekd_pkg::LINE_MAX];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ekd_parser.sv =====
module ekd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          key_present,
   input  logic [7:0]                    key_byte,
   input  logic                          clear_line,
   output ekd_pkg::wr_req_type           wr,
   output logic [3:0]                    command,
   output logic [ekd_pkg::CNT_W-1:0]     line_length
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ESC   = 2'd1;
   localparam logic [1:0] ST_CSI   = 2'd2;
   localparam logic [1:0] ST_TILDE = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [ekd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [ekd_pkg::CNT_W-1:0] base;
   logic [ekd_pkg::CNT_W-1:0] plain_count;
   logic [3:0]                plain_cmd;
   logic                      plain_wr;
   logic                      use_plain;
   logic [3:0]                cmd;

   // line edit for a byte outside a sequence
   always_comb begin
      base        = clear_line ? '0 : count_ff;
      plain_cmd   = ekd_pkg::ACT_NONE;
      plain_count = base;
      plain_wr    = 1'b0;
      if (key_byte == ekd_pkg::KEY_BS || key_byte == ekd_pkg::KEY_DEL) begin
         if (base != '0) begin
            plain_count = base - ekd_pkg::CNT_ONE;
         end
      end else if (ekd_pkg::is_printable(key_byte)) begin
         if (base < ekd_pkg::LINE_MAX_CNT) begin
            plain_wr    = 1'b1;
            plain_count = base + ekd_pkg::CNT_ONE;
         end
      end else if (key_byte == ekd_pkg::KEY_LF || key_byte == ekd_pkg::KEY_CR) begin
         plain_cmd = ekd_pkg::ACT_LINE;
      end
   end

   // escape sequence parser
   always_comb begin
      state_in  = state_ff;
      cmd       = ekd_pkg::ACT_NONE;
      use_plain = 1'b0;
      if (key_present) begin
         if (key_byte == ekd_pkg::KEY_QUIT) begin
            cmd = ekd_pkg::ACT_QUIT;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (key_byte == ekd_pkg::KEY_ESC) begin
                     state_in = ST_ESC;
                  end else begin
                     use_plain = 1'b1;
                  end
               end
               ST_ESC: begin
                  if (key_byte == ekd_pkg::KEY_BRACKET) begin
                     state_in = ST_CSI;
                  end else begin
                     state_in  = ST_IDLE;
                     use_plain = 1'b1;
                  end
               end
               ST_CSI: begin
                  state_in = ST_IDLE;
                  if (key_byte == ekd_pkg::KEY_UP) begin
                     cmd = ekd_pkg::ACT_UP;
                  end else if (key_byte == ekd_pkg::KEY_DOWN) begin
                     cmd = ekd_pkg::ACT_DOWN;
                  end else if (key_byte == ekd_pkg::KEY_RIGHT) begin
                     cmd = ekd_pkg::ACT_RIGHT;
                  end else if (key_byte == ekd_pkg::KEY_LEFT) begin
                     cmd = ekd_pkg::ACT_LEFT;
                  end else if (key_byte == ekd_pkg::KEY_ONE) begin
                     cmd      = ekd_pkg::ACT_ENTER;
                     state_in = ST_TILDE;
                  end else if (key_byte == ekd_pkg::KEY_TWO) begin
                     cmd      = ekd_pkg::ACT_SHIFT_LEFT;
                     state_in = ST_TILDE;
                  end else if (key_byte == ekd_pkg::KEY_FIVE) begin
                     cmd      = ekd_pkg::ACT_SHIFT_RIGHT;
                     state_in = ST_TILDE;
                  end else begin
                     use_plain = 1'b1;
                  end
               end
               ST_TILDE: begin
                  state_in = ST_IDLE;
                  if (key_byte != ekd_pkg::KEY_TILDE) begin
                     use_plain = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
      end
      if (use_plain) begin
         cmd = plain_cmd;
      end
      count_in = use_plain ? plain_count : base;
   end

   // store write goes to the old tail
   always_comb begin
      wr.en   = accept && use_plain && plain_wr;
      wr.addr = base[ekd_pkg::IDX_W-1:0];
      wr.data = key_byte;
   end

   assign command     = cmd;
   assign line_length = count_in;

   // parser state and line count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule
